/* sv/gsp_pkg.sv */
// Shared types, codes and sizes of the generational slot pool.
package gsp_pkg;

   localparam int SLOT_COUNT    = 16;
   localparam int PAYLOAD_BYTES = 32;
   localparam int SLOT_W        = $clog2(SLOT_COUNT);
   localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
   localparam int LEN_W         = 6;
   localparam int CNT_W         = 5;
   localparam int GEN_W         = 32;
   localparam int MEM_AW        = SLOT_W + IDX_W;
   localparam int ADDR_W        = 3;

   localparam logic [GEN_W-1:0] GEN_MAX     = '1;
   localparam logic [CNT_W-1:0] RETIRE_MAX  = '1;
   localparam logic [CNT_W-1:0] SLOTS_RESET = CNT_W'(SLOT_COUNT);

   localparam logic [1:0] CMD_ACQUIRE = 2'd0;
   localparam logic [1:0] CMD_COPY    = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   localparam logic REG_SLOTS_IN_USE = 1'b0;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_INVALID   = 3'd1,
      ST_EXHAUSTED = 3'd2,
      ST_STALE     = 3'd3,
      ST_TOO_SMALL = 3'd4
   } gsp_status_type;

   typedef enum logic [2:0] {
      IDLE, EVAL, MOVE_RD, MOVE_WR, COPY_RD, COPY_OUT
   } gsp_state_type;

   typedef struct packed {
      logic [1:0]       command;
      logic [3:0]       slot_index;
      logic [GEN_W-1:0] handle_generation;
      logic [7:0]       data_byte;
      logic             last_byte;
      logic [15:0]      copy_capacity;
   } gsp_req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [3:0]       out_slot;
      logic [GEN_W-1:0] out_generation;
      logic [7:0]       out_byte;
      logic [LEN_W-1:0] length_out;
      logic             last_out;
      logic [CNT_W-1:0] used_count;
      logic [CNT_W-1:0] peak_count;
      logic [31:0]      exhausted_count;
      logic [31:0]      stale_count;
      logic [CNT_W-1:0] retired_count;
   } gsp_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic eval;
      logic move_rd;
      logic move_wr;
      logic copy_rd;
      logic copy_out;
   } gsp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic stage_only;
      logic out_busy;
      logic go_move;
      logic go_copy;
      logic idx_last;
   } gsp_stat_type;

endpackage

/* sv/gsp_req_if.sv */
// Request channel: valid/ready plus one request word.
interface gsp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [3:0]  slot_index;
   logic [31:0] handle_generation;
   logic [7:0]  data_byte;
   logic        last_byte;
   logic [15:0] copy_capacity;

   modport source (output valid, command, slot_index, handle_generation, data_byte,
                   last_byte, copy_capacity, input ready);
   modport sink (input valid, command, slot_index, handle_generation, data_byte,
                 last_byte, copy_capacity, output ready);
endinterface

/* sv/gsp_rsp_if.sv */
// Response channel: valid/ready plus one response word.
interface gsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [3:0]  out_slot;
   logic [31:0] out_generation;
   logic [7:0]  out_byte;
   logic [5:0]  length_out;
   logic        last_out;
   logic [4:0]  used_count;
   logic [4:0]  peak_count;
   logic [31:0] exhausted_count;
   logic [31:0] stale_count;
   logic [4:0]  retired_count;

   modport source (output valid, status, out_slot, out_generation, out_byte, length_out,
                   last_out, used_count, peak_count, exhausted_count, stale_count,
                   retired_count, input ready);
   modport sink (input valid, status, out_slot, out_generation, out_byte, length_out,
                 last_out, used_count, peak_count, exhausted_count, stale_count,
                 retired_count, output ready);
endinterface

/* sv/gsp_ctrl.sv */
// Sequencer of the slot pool: accept, evaluate, byte move and copy-out loops.
module gsp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gsp_pkg::gsp_stat_type stat,
   output gsp_pkg::gsp_cmd_type  cmd
);
   import gsp_pkg::*;

   gsp_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid && !stat.stage_only) state_in = EVAL;
         end
         EVAL: begin
            if (!stat.out_busy) begin
               if (stat.go_move) state_in = MOVE_RD;
               else if (stat.go_copy) state_in = COPY_RD;
               else state_in = IDLE;
            end
         end
         MOVE_RD: state_in = MOVE_WR;
         MOVE_WR: state_in = stat.idx_last ? IDLE : MOVE_RD;
         COPY_RD: state_in = COPY_OUT;
         COPY_OUT: begin
            if (!stat.out_busy) state_in = stat.idx_last ? IDLE : COPY_RD;
         end
         default: state_in = IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         IDLE: begin
            // hold off requests while reset is high
            req_ready = !reset;
            cmd.take  = req_valid && !reset;
         end
         EVAL:     cmd.eval     = !stat.out_busy;
         MOVE_RD:  cmd.move_rd  = 1'b1;
         MOVE_WR:  cmd.move_wr  = 1'b1;
         COPY_RD:  cmd.copy_rd  = 1'b1;
         COPY_OUT: cmd.copy_out = !stat.out_busy;
         default: ;
      endcase
   end

endmodule

/* sv/gsp_dp.sv */
// Datapath of the slot pool: slot table, staging and payload memories, statistics, output word.
module gsp_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [4:0]            slots_in_use,
   input  gsp_pkg::gsp_req_type  req,
   input  gsp_pkg::gsp_cmd_type  cmd,
   output gsp_pkg::gsp_stat_type stat,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output gsp_pkg::gsp_rsp_type  rsp
);
   import gsp_pkg::*;

   logic [1:0]        cmd_ff;
   logic [SLOT_W-1:0] sidx_ff;
   logic [GEN_W-1:0]  hgen_ff;
   logic [15:0]       cap_ff;

   logic [7:0]        stage_mem [PAYLOAD_BYTES];
   logic [LEN_W-1:0]  stage_count_ff;
   logic              stage_ovf_ff;
   logic [7:0]        slot_mem [SLOT_COUNT*PAYLOAD_BYTES];

   logic [SLOT_COUNT-1:0] busy_ff;
   logic [GEN_W-1:0]      gen_ff [SLOT_COUNT];
   logic [LEN_W-1:0]      slot_len_ff [SLOT_COUNT];

   logic [SLOT_W-1:0] sel_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [LEN_W-1:0]  xfer_len_ff;
   logic [GEN_W-1:0]  new_gen_ff;
   logic [7:0]        stage_rd_ff, slot_rd_ff;

   logic [CNT_W-1:0]  held_ff, peak_ff, retire_ff;
   logic [31:0]       exhaust_ff, stale_ff;

   logic              out_valid_ff;
   logic [2:0]        ostatus_ff;
   logic [SLOT_W-1:0] oslot_ff;
   logic [GEN_W-1:0]  ogen_ff;
   logic [7:0]        obyte_ff;
   logic [LEN_W-1:0]  olen_ff;
   logic              olast_ff;

   logic              free_found;
   logic [SLOT_W-1:0] free_slot;
   logic [SLOT_W-1:0] look_slot;
   logic [GEN_W-1:0]  look_gen;
   logic [LEN_W-1:0]  look_len;
   logic              hit, acq_ok, copy_ok, idx_last;
   logic              ev_emit;
   gsp_status_type    ev_status;
   logic              out_load;
   logic [CNT_W-1:0]  held_in;
   logic [MEM_AW-1:0] mem_addr;

   // lowest managed slot that is neither held nor retired
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
         if ((CNT_W'(s) < slots_in_use) && !busy_ff[s] && (gen_ff[s] != GEN_MAX)) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(s);
         end
      end
   end

   assign look_slot = (cmd_ff == CMD_ACQUIRE) ? free_slot : sidx_ff;
   assign look_gen  = gen_ff[look_slot];
   assign look_len  = slot_len_ff[look_slot];
   assign hit = ({1'b0, sidx_ff} < slots_in_use) && (hgen_ff != '0) && busy_ff[sidx_ff]
                && (look_gen == hgen_ff);
   assign acq_ok   = !stage_ovf_ff && free_found;
   assign copy_ok  = hit && ({10'b0, look_len} <= cap_ff);
   assign idx_last = ({1'b0, idx_ff} + LEN_W'(1)) == xfer_len_ff;
   assign held_in  = held_ff + CNT_W'(1);
   assign mem_addr = {sel_ff, idx_ff};

   always_comb begin
      ev_emit   = 1'b1;
      ev_status = ST_INVALID;
      case (cmd_ff)
         CMD_ACQUIRE: begin
            if (stage_ovf_ff) ev_status = ST_INVALID;
            else if (!free_found) ev_status = ST_EXHAUSTED;
            else ev_emit = 1'b0;
         end
         CMD_COPY: begin
            if (!hit) ev_status = ST_STALE;
            else if (!copy_ok) ev_status = ST_TOO_SMALL;
            else ev_emit = 1'b0;
         end
         CMD_RELEASE: ev_status = hit ? ST_OK : ST_STALE;
         default: ev_status = ST_INVALID;
      endcase
   end

   assign stat.stage_only = (req.command == CMD_ACQUIRE) && !req.last_byte;
   assign stat.out_busy   = out_valid_ff;
   assign stat.go_move    = (cmd_ff == CMD_ACQUIRE) && acq_ok;
   assign stat.go_copy    = (cmd_ff == CMD_COPY) && copy_ok;
   assign stat.idx_last   = idx_last;

   // latch request, stage acquire bytes
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         cmd_ff  <= req.command;
         sidx_ff <= req.slot_index;
         hgen_ff <= req.handle_generation;
         cap_ff  <= req.copy_capacity;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && (req.command == CMD_ACQUIRE) && (stage_count_ff < LEN_W'(PAYLOAD_BYTES)))
         stage_mem[stage_count_ff[IDX_W-1:0]] <= req.data_byte;
      if (cmd.move_rd) stage_rd_ff <= stage_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_count_ff <= '0;
         stage_ovf_ff   <= 1'b0;
      end else if (cmd.take && (req.command == CMD_ACQUIRE)) begin
         if (stage_count_ff < LEN_W'(PAYLOAD_BYTES)) stage_count_ff <= stage_count_ff + LEN_W'(1);
         else stage_ovf_ff <= 1'b1;
      end else if (cmd.eval && (cmd_ff == CMD_ACQUIRE)) begin
         stage_count_ff <= '0;
         stage_ovf_ff   <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.move_wr) slot_mem[mem_addr] <= stage_rd_ff;
      if (cmd.copy_rd) slot_rd_ff <= slot_mem[mem_addr];
   end

   // slot table and statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= '0;
         held_ff    <= '0;
         peak_ff    <= '0;
         retire_ff  <= '0;
         exhaust_ff <= '0;
         stale_ff   <= '0;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            gen_ff[s]      <= '0;
            slot_len_ff[s] <= '0;
         end
      end else if (cmd.eval) begin
         case (cmd_ff)
            CMD_ACQUIRE: begin
               if (acq_ok) begin
                  busy_ff[free_slot]     <= 1'b1;
                  gen_ff[free_slot]      <= look_gen + GEN_W'(1);
                  slot_len_ff[free_slot] <= stage_count_ff;
                  held_ff                <= held_in;
                  if (held_in > peak_ff) peak_ff <= held_in;
               end else if (!stage_ovf_ff && (exhaust_ff != '1)) begin
                  exhaust_ff <= exhaust_ff + 32'd1;
               end
            end
            CMD_COPY, CMD_RELEASE: begin
               if (!hit) begin
                  if (stale_ff != '1) stale_ff <= stale_ff + 32'd1;
               end else if (cmd_ff == CMD_RELEASE) begin
                  busy_ff[sidx_ff]     <= 1'b0;
                  slot_len_ff[sidx_ff] <= '0;
                  if (held_ff != '0) held_ff <= held_ff - CNT_W'(1);
                  if ((look_gen == GEN_MAX) && (retire_ff != RETIRE_MAX))
                     retire_ff <= retire_ff + CNT_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // transfer loop bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         idx_ff      <= '0;
         sel_ff      <= look_slot;
         xfer_len_ff <= (cmd_ff == CMD_ACQUIRE) ? stage_count_ff : look_len;
         new_gen_ff  <= look_gen + GEN_W'(1);
      end else if (cmd.move_wr || cmd.copy_out) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   // output word
   assign out_load = (cmd.eval && ev_emit) || (cmd.move_wr && idx_last) || cmd.copy_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         ostatus_ff <= ST_OK;
         oslot_ff   <= '0;
         ogen_ff    <= '0;
         obyte_ff   <= '0;
         olen_ff    <= '0;
         olast_ff   <= 1'b1;
         if (cmd.eval) begin
            ostatus_ff <= ev_status;
         end else if (cmd.move_wr) begin
            oslot_ff <= sel_ff;
            ogen_ff  <= new_gen_ff;
         end else begin
            obyte_ff <= slot_rd_ff;
            olen_ff  <= xfer_len_ff;
            olast_ff <= idx_last;
         end
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp.status          = ostatus_ff;
   assign rsp.out_slot        = oslot_ff;
   assign rsp.out_generation  = ogen_ff;
   assign rsp.out_byte        = obyte_ff;
   assign rsp.length_out      = olen_ff;
   assign rsp.last_out        = olast_ff;
   assign rsp.used_count      = held_ff;
   assign rsp.peak_count      = peak_ff;
   assign rsp.exhausted_count = exhaust_ff;
   assign rsp.stale_count     = stale_ff;
   assign rsp.retired_count   = retire_ff;

endmodule

/* sv/generational_slot_pool.sv */
// Top level of the generational slot pool: register port, sequencer and datapath.
//
// Requests arrive on req_ch (valid/ready), one word per acquire byte, copy or
// release. Results leave on rsp_ch (valid/ready) from an output register; a
// copy yields one word per stored byte, every other finished command one word.
// Acquire bytes not marked last give no word. On a last acquire byte the staged
// bytes move into the claimed slot one at a time through the staging memory
// read register. A copy is paced by the payload memory read port; release,
// rejected commands and failed acquires only pass through accept and evaluate.
// The next request is taken as soon as the last word of the previous one is
// loaded, even while that word still waits in the output register.
// A stalled receiver holds the output register; the sequencer waits in place.
// Reset (synchronous, active high) clears all slots, generations, statistics
// and staging; slots_in_use returns to 16. No clearing pass is needed.
// slots_in_use sits at byte address 0 of the APB port; the user must write it
// only while the pool is idle, which the block itself does not enforce. Writes
// with pwdata[4:0] of 0 or above 16 are ignored.
module generational_slot_pool (
   input  logic                        clock,
   input  logic                        reset,
   gsp_req_if.sink                     req_ch,
   gsp_rsp_if.source                   rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [gsp_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import gsp_pkg::*;

   logic [CNT_W-1:0] slots_ff;
   logic [CNT_W-1:0] wr_value;
   logic             wr_hit;
   gsp_req_type      req;
   gsp_rsp_type      rsp;
   gsp_cmd_type      cmd;
   gsp_stat_type     stat;
   logic             rsp_valid;

   assign pready   = 1'b1;
   assign wr_value = pwdata[CNT_W-1:0];
   assign wr_hit   = psel && penable && pwrite && (paddr[2] == REG_SLOTS_IN_USE);
   assign prdata   = (paddr[2] == REG_SLOTS_IN_USE) ? {27'b0, slots_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= SLOTS_RESET;
      end else if (wr_hit && (wr_value != '0) && (wr_value <= CNT_W'(SLOT_COUNT))) begin
         slots_ff <= wr_value;
      end
   end

   assign req.command           = req_ch.command;
   assign req.slot_index        = req_ch.slot_index;
   assign req.handle_generation = req_ch.handle_generation;
   assign req.data_byte         = req_ch.data_byte;
   assign req.last_byte         = req_ch.last_byte;
   assign req.copy_capacity     = req_ch.copy_capacity;

   gsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gsp_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .slots_in_use (slots_ff),
      .req          (req),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_valid),
      .rsp          (rsp)
   );

   assign rsp_ch.valid           = rsp_valid;
   assign rsp_ch.status          = rsp.status;
   assign rsp_ch.out_slot        = rsp.out_slot;
   assign rsp_ch.out_generation  = rsp.out_generation;
   assign rsp_ch.out_byte        = rsp.out_byte;
   assign rsp_ch.length_out      = rsp.length_out;
   assign rsp_ch.last_out        = rsp.last_out;
   assign rsp_ch.used_count      = rsp.used_count;
   assign rsp_ch.peak_count      = rsp.peak_count;
   assign rsp_ch.exhausted_count = rsp.exhausted_count;
   assign rsp_ch.stale_count     = rsp.stale_count;
   assign rsp_ch.retired_count   = rsp.retired_count;

   a_peak_covers_held: assert property (@(posedge clock) disable iff (reset)
      rsp.used_count <= rsp.peak_count)
      else $error("held slots exceed peak count");

   a_exhaust_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status == ST_EXHAUSTED) |-> rsp.exhausted_count != '0)
      else $error("exhausted word without tally");

   a_stale_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status == ST_STALE) |-> rsp.stale_count != '0)
      else $error("stale word without tally");

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> !cmd.eval && !cmd.move_wr && !cmd.copy_out)
      else $error("request taken during a transfer");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench of the generational slot pool: directed and random traffic.
module testbench;
   import gsp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;

   gsp_req_if req_ch();
   gsp_rsp_if rsp_ch();

   generational_slot_pool dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   localparam int LATENCY = 2 + 2 * PAYLOAD_BYTES + 8;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // pool state as predicted
   logic [CNT_W-1:0] pool_slots;
   bit               pool_busy [SLOT_COUNT];
   logic [GEN_W-1:0] pool_gen [SLOT_COUNT];
   int               pool_len [SLOT_COUNT];
   logic [7:0]       pool_data [SLOT_COUNT][PAYLOAD_BYTES];
   logic [7:0]       stage_data [PAYLOAD_BYTES];
   int               stage_n;
   bit               stage_ovf;
   int               held, peak, retired;
   logic [31:0]      exhaust_tally, stale_tally;

   gsp_rsp_type expected_words[$];
   int  fail_count;
   bit  calm;
   int  stall_left;

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic void push_word(gsp_status_type st, int slot, logic [31:0] gen,
                                     logic [7:0] data, int len, bit last);
      gsp_rsp_type w;
      w.status          = st;
      w.out_slot        = 4'(slot);
      w.out_generation  = gen;
      w.out_byte        = data;
      w.length_out      = LEN_W'(len);
      w.last_out        = last;
      w.used_count      = CNT_W'(held);
      w.peak_count      = CNT_W'(peak);
      w.exhausted_count = exhaust_tally;
      w.stale_count     = stale_tally;
      w.retired_count   = CNT_W'(retired);
      expected_words.push_back(w);
   endfunction

   function automatic bit handle_valid(logic [3:0] slot, logic [31:0] gen);
      if (slot < pool_slots && gen != 0 && pool_busy[slot] && pool_gen[slot] == gen)
         return 1'b1;
      if (stale_tally != '1) stale_tally++;
      return 1'b0;
   endfunction

   function automatic void pool_predict(gsp_req_type r);
      int len;
      bit claimed;
      claimed = 1'b0;
      case (r.command)
         CMD_ACQUIRE: begin
            if (stage_n < PAYLOAD_BYTES) stage_data[stage_n++] = r.data_byte;
            else stage_ovf = 1'b1;
            if (r.last_byte) begin
               len = stage_n;
               stage_n = 0;
               if (stage_ovf) begin
                  stage_ovf = 1'b0;
                  push_word(ST_INVALID, 0, 0, 0, 0, 1);
               end else begin
                  for (int s = 0; s < pool_slots && !claimed; s++) begin
                     if (!pool_busy[s] && pool_gen[s] != GEN_MAX) begin
                        for (int i = 0; i < len; i++) pool_data[s][i] = stage_data[i];
                        pool_len[s] = len;
                        pool_gen[s]++;
                        pool_busy[s] = 1'b1;
                        held++;
                        if (held > peak) peak = held;
                        push_word(ST_OK, s, pool_gen[s], 0, 0, 1);
                        claimed = 1'b1;
                     end
                  end
                  if (!claimed) begin
                     if (exhaust_tally != '1) exhaust_tally++;
                     push_word(ST_EXHAUSTED, 0, 0, 0, 0, 1);
                  end
               end
            end
         end
         CMD_COPY: begin
            if (!handle_valid(r.slot_index, r.handle_generation))
               push_word(ST_STALE, 0, 0, 0, 0, 1);
            else begin
               len = pool_len[r.slot_index];
               if (r.copy_capacity < len) push_word(ST_TOO_SMALL, 0, 0, 0, 0, 1);
               else if (len == 0) push_word(ST_OK, 0, 0, 0, 0, 1);
               else
                  for (int i = 0; i < len; i++)
                     push_word(ST_OK, 0, 0, pool_data[r.slot_index][i], len, i == len - 1);
            end
         end
         CMD_RELEASE: begin
            if (!handle_valid(r.slot_index, r.handle_generation))
               push_word(ST_STALE, 0, 0, 0, 0, 1);
            else begin
               pool_len[r.slot_index] = 0;
               pool_busy[r.slot_index] = 1'b0;
               if (held > 0) held--;
               if (pool_gen[r.slot_index] == GEN_MAX && retired < 31) retired++;
               push_word(ST_OK, 0, 0, 0, 0, 1);
            end
         end
         default: push_word(ST_INVALID, 0, 0, 0, 0, 1);
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      gsp_rsp_type w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_words.size() == 0)
            report("unexpected word", 32'(rsp_ch.status), 0);
         else begin
            w = expected_words.pop_front();
            if (rsp_ch.status !== w.status)
               report("status", 32'(rsp_ch.status), 32'(w.status));
            if (rsp_ch.out_slot !== w.out_slot)
               report("out_slot", 32'(rsp_ch.out_slot), 32'(w.out_slot));
            if (rsp_ch.out_generation !== w.out_generation)
               report("out_generation", rsp_ch.out_generation, w.out_generation);
            if (rsp_ch.out_byte !== w.out_byte)
               report("out_byte", 32'(rsp_ch.out_byte), 32'(w.out_byte));
            if (rsp_ch.length_out !== w.length_out)
               report("length_out", 32'(rsp_ch.length_out), 32'(w.length_out));
            if (rsp_ch.last_out !== w.last_out)
               report("last_out", 32'(rsp_ch.last_out), 32'(w.last_out));
            if (rsp_ch.used_count !== w.used_count)
               report("used_count", 32'(rsp_ch.used_count), 32'(w.used_count));
            if (rsp_ch.peak_count !== w.peak_count)
               report("peak_count", 32'(rsp_ch.peak_count), 32'(w.peak_count));
            if (rsp_ch.exhausted_count !== w.exhausted_count)
               report("exhausted_count", rsp_ch.exhausted_count, w.exhausted_count);
            if (rsp_ch.stale_count !== w.stale_count)
               report("stale_count", rsp_ch.stale_count, w.stale_count);
            if (rsp_ch.retired_count !== w.retired_count)
               report("retired_count", 32'(rsp_ch.retired_count), 32'(w.retired_count));
         end
      end
   end

   // receiver stalls in bursts
   always @(posedge clock) begin
      if (calm) rsp_ch.ready <= 1'b1;
      else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_ch.ready <= 1'b0;
      end else
         rsp_ch.ready <= 1'b1;
   end

   task automatic send_word(logic [1:0] cmd, logic [3:0] slot, logic [31:0] gen,
                            logic [7:0] data, bit last, logic [15:0] cap);
      gsp_req_type r;
      r = '{command: cmd, slot_index: slot, handle_generation: gen, data_byte: data,
            last_byte: last, copy_capacity: cap};
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.slot_index <= slot;
      req_ch.handle_generation <= gen;
      req_ch.data_byte <= data;
      req_ch.last_byte <= last;
      req_ch.copy_capacity <= cap;
      do @(posedge clock); while (!req_ch.ready);
      pool_predict(r);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic acquire(int len, bit rnd);
      for (int i = 0; i < len; i++)
         send_word(CMD_ACQUIRE, 4'($urandom), $urandom,
                   rnd ? 8'($urandom) : 8'(i * 37 + len), i == len - 1, 16'($urandom));
   endtask

   // first busy reachable slot from a random start, -1 if none
   function automatic int pick_busy();
      int start;
      start = $urandom_range(0, SLOT_COUNT - 1);
      for (int k = 0; k < SLOT_COUNT; k++)
         if (pool_busy[(start + k) % SLOT_COUNT] && (start + k) % SLOT_COUNT < pool_slots)
            return (start + k) % SLOT_COUNT;
      return -1;
   endfunction

   task automatic csr_write(logic [31:0] value);
      drain();
      repeat (LATENCY) @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= ADDR_W'(4 * int'(REG_SLOTS_IN_USE)); pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0;
      if (value[4:0] != 0 && value[4:0] <= SLOT_COUNT) pool_slots = value[4:0];
      // read back
      @(posedge clock);
      pwrite <= 1'b0; psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[CNT_W-1:0] !== pool_slots)
         report("slots_in_use readback", prdata, 32'(pool_slots));
      psel <= 1'b0; penable <= 1'b0;
   endtask

   task automatic test_directed();
      acquire(1, 0);                                   // slot 0, one byte
      send_word(CMD_ACQUIRE, 0, 0, 8'hFF, 0, 0);
      send_word(CMD_ACQUIRE, 0, 0, 8'h00, 0, 0);
      // copy in the middle of staging leaves staged bytes alone
      send_word(CMD_COPY, 0, 1, 0, 0, 16'hFFFF);
      send_word(CMD_ACQUIRE, 0, 0, 8'h5A, 1, 0);       // slot 1, three bytes
      send_word(CMD_COPY, 1, 1, 0, 0, 3);
      send_word(CMD_COPY, 1, 1, 0, 0, 2);              // too small
      send_word(CMD_COPY, 1, 1, 0, 0, 0);
      send_word(CMD_COPY, 1, 0, 0, 0, 16'hFFFF);       // generation zero
      send_word(CMD_COPY, 15, 32'hFFFF_FFFF, 0, 0, 16'hFFFF);
      send_word(CMD_RELEASE, 1, 1, 0, 0, 0);
      send_word(CMD_RELEASE, 1, 1, 0, 0, 0);           // released twice
      send_word(CMD_COPY, 1, 1, 0, 0, 16'hFFFF);
      send_word(2'd3, 4'hF, 32'hFFFF_FFFF, 8'hFF, 1, 16'hFFFF);
      send_word(CMD_RELEASE, 0, 2, 0, 0, 0);           // wrong generation
      send_word(CMD_RELEASE, 0, 1, 0, 0, 0);
      acquire(1, 0);                                   // slot 0 again, generation 2
   endtask

   task automatic test_lengths();
      acquire(PAYLOAD_BYTES, 1);
      send_word(CMD_COPY, 1, 1, 0, 0, PAYLOAD_BYTES);
      acquire(PAYLOAD_BYTES + 3, 1);                   // over length
      acquire(2, 1);
   endtask

   task automatic test_exhaust();
      csr_write(2);
      acquire(1, 1);
      acquire(1, 1);
      send_word(CMD_COPY, 2, 1, 0, 0, 16'hFFFF);       // slot beyond the count
      csr_write(0);
      csr_write(17);
      csr_write(31);
      csr_write(1);
      acquire(1, 1);
      csr_write(SLOT_COUNT);
   endtask

   task automatic test_random(int items, bit tail);
      int n, s, len;
      n = 0;
      while (n < items) begin
         // drop idling in the closing stretch of the run
         if (tail && n > items * 4 / 5) calm = 1'b1;
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, PAYLOAD_BYTES + 4)
                                                 : $urandom_range(1, 4);
               acquire(len, 1);
               n += len;
            end
            3, 4, 5: begin
               s = pick_busy();
               if (s >= 0)
                  send_word(CMD_COPY, 4'(s), pool_gen[s], 0, 0,
                            ($urandom_range(0, 4) == 0) ? 16'(pool_len[s] - 1) :
                            16'($urandom_range(pool_len[s], 65535)));
               n++;
            end
            6, 7: begin
               s = pick_busy();
               if (s >= 0) send_word(CMD_RELEASE, 4'(s), pool_gen[s], 0, 0, 0);
               n++;
            end
            8: begin
               send_word(2'($urandom_range(1, 3)), 4'($urandom), ($urandom_range(0, 1) ?
                         32'($urandom_range(0, 3)) : $urandom), 8'($urandom),
                         1'($urandom), 16'($urandom));
               n++;
            end
            default: begin
               if ($urandom_range(0, 3) == 0) drain();
            end
         endcase
      end
   endtask

   initial begin
      timeout_guard: begin end
      reset = 1'b1;
      calm = 1'b0;
      stall_left = 0;
      fail_count = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      req_ch.valid = 0; req_ch.command = CMD_ACQUIRE; req_ch.slot_index = 0;
      req_ch.handle_generation = 0; req_ch.data_byte = 0; req_ch.last_byte = 0;
      req_ch.copy_capacity = 0;
      rsp_ch.ready = 0;
      pool_slots = CNT_W'(SLOT_COUNT);
      for (int s = 0; s < SLOT_COUNT; s++) begin
         pool_busy[s] = 0; pool_gen[s] = 0; pool_len[s] = 0;
      end
      stage_n = 0; stage_ovf = 0; held = 0; peak = 0; retired = 0;
      exhaust_tally = 0; stale_tally = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_lengths();
      test_exhaust();
      test_random(50, 1'b0);
      csr_write(5);
      test_random(40, 1'b0);
      csr_write(SLOT_COUNT);
      test_random(50, 1'b1);

      drain();
      repeat (LATENCY) @(posedge clock);
      if (expected_words.size() != 0) report("words never came", expected_words.size(), 0);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule
